[rtl/tdtc_pkg.sv]
package tdtc_pkg;

  localparam logic [15:0] TAG_WIDTH    = 16'h0100;
  localparam logic [15:0] TAG_HEIGHT   = 16'h0101;
  localparam logic [15:0] TAG_BITS     = 16'h0102;
  localparam logic [15:0] TAG_COMPRESS = 16'h0103;
  localparam logic [15:0] TAG_PHOTO    = 16'h0106;
  localparam logic [15:0] TAG_STRIPOFS = 16'h0111;
  localparam logic [15:0] TAG_SPP      = 16'h0115;
  localparam logic [15:0] TAG_ROWS     = 16'h0116;
  localparam logic [15:0] TAG_PLANAR   = 16'h011c;
  localparam logic [15:0] TAG_CMAP     = 16'h0140;

  localparam logic [15:0] TYPE_SHORT = 16'd3;
  localparam logic [15:0] TYPE_LONG  = 16'd4;

  localparam logic [31:0] CMAP_COUNT_FOUR  = 32'd48;
  localparam logic [31:0] CMAP_COUNT_EIGHT = 32'd768;
  localparam logic [8:0]  PAL_SIZE_FOUR    = 9'd16;
  localparam logic [8:0]  PAL_SIZE_EIGHT   = 9'd256;

  localparam logic [31:0] BITS_FOUR     = 32'd4;
  localparam logic [31:0] BITS_EIGHT    = 32'd8;
  localparam logic [31:0] COMPRESS_RAW  = 32'd1;
  localparam logic [31:0] COMPRESS_LZW  = 32'd5;
  localparam logic [31:0] VALUE_ONE     = 32'd1;

  localparam int F_WIDTH    = 1;
  localparam int F_HEIGHT   = 2;
  localparam int F_BITS     = 3;
  localparam int F_COMPRESS = 4;
  localparam int F_PHOTO    = 5;
  localparam int F_STRIPOFS = 6;
  localparam int F_SPP      = 7;
  localparam int F_PLANAR   = 8;
  localparam int F_CMAP     = 9;
  localparam int F_ROWS     = 10;

  localparam logic [10:0] F_REQUIRED = 11'b001_1111_1110;

  localparam logic [1:0] DEPTH_ILLEGAL = 2'd0;
  localparam logic [1:0] DEPTH_FOUR    = 2'd2;
  localparam logic [1:0] DEPTH_EIGHT   = 2'd3;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_REQ_MISSING  = 3'd1,
    ST_ROWS_MISSING = 3'd2,
    ST_CMAP_MISSING = 3'd3,
    ST_BAD_DEPTH    = 3'd4
  } tdtc_status_t;

  typedef struct packed {
    logic [10:0] seen;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  depth;
    logic        comp;
    logic [31:0] strips;
    logic [31:0] single_ofs;
    logic [31:0] table_ofs;
    logic [31:0] rows;
    logic [31:0] cmap_ofs;
    logic [8:0]  pal_size;
  } tdtc_state_t;

  typedef struct packed {
    tdtc_status_t status;
    logic [15:0]  width;
    logic [15:0]  height;
    logic         eight_bit;
    logic         lzw;
    logic [31:0]  strip_count;
    logic [31:0]  strip_location;
    logic [31:0]  rows_per_strip;
    logic [31:0]  colormap_offset;
    logic [8:0]   palette_entries;
    logic [15:0]  line_bytes;
    logic [1:0]   row_padding;
  } tdtc_result_t;

endpackage

[rtl/tdtc_entry.sv]
module tdtc_entry (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [15:0]           tag_id,
  input  logic [15:0]           field_type,
  input  logic [31:0]           value_count,
  input  logic [31:0]           tag_value,
  input  logic                  last_entry,
  output tdtc_pkg::tdtc_state_t st_nxt
);

  tdtc_pkg::tdtc_state_t st_r;
  logic                  short1;

  assign short1 = (field_type == tdtc_pkg::TYPE_SHORT) && (value_count == tdtc_pkg::VALUE_ONE);

  always_comb begin
    st_nxt = st_r;
    case (tag_id)
      tdtc_pkg::TAG_WIDTH: begin
        if (short1) begin
          st_nxt.width = tag_value[15:0];
          st_nxt.seen[tdtc_pkg::F_WIDTH] = 1'b1;
        end
      end
      tdtc_pkg::TAG_HEIGHT: begin
        if (short1) begin
          st_nxt.height = tag_value[15:0];
          st_nxt.seen[tdtc_pkg::F_HEIGHT] = 1'b1;
        end
      end
      tdtc_pkg::TAG_BITS: begin
        if (short1 && (tag_value == tdtc_pkg::BITS_FOUR || tag_value == tdtc_pkg::BITS_EIGHT))
        begin
          st_nxt.depth = (tag_value == tdtc_pkg::BITS_FOUR) ? tdtc_pkg::DEPTH_FOUR
                                                            : tdtc_pkg::DEPTH_EIGHT;
          st_nxt.seen[tdtc_pkg::F_BITS] = 1'b1;
        end
      end
      tdtc_pkg::TAG_COMPRESS: begin
        if (short1 && (tag_value == tdtc_pkg::COMPRESS_RAW ||
                       tag_value == tdtc_pkg::COMPRESS_LZW)) begin
          st_nxt.comp = (tag_value == tdtc_pkg::COMPRESS_LZW);
          st_nxt.seen[tdtc_pkg::F_COMPRESS] = 1'b1;
        end
      end
      tdtc_pkg::TAG_PHOTO: begin
        if (short1) begin
          st_nxt.seen[tdtc_pkg::F_PHOTO] = 1'b1;
        end
      end
      tdtc_pkg::TAG_STRIPOFS: begin
        if (field_type == tdtc_pkg::TYPE_LONG) begin
          st_nxt.strips = value_count;
          if (value_count == tdtc_pkg::VALUE_ONE) begin
            st_nxt.single_ofs = tag_value;
          end else begin
            st_nxt.table_ofs = tag_value;
          end
          st_nxt.seen[tdtc_pkg::F_STRIPOFS] = 1'b1;
        end
      end
      tdtc_pkg::TAG_SPP: begin
        if (short1 && tag_value == tdtc_pkg::VALUE_ONE) begin
          st_nxt.seen[tdtc_pkg::F_SPP] = 1'b1;
        end
      end
      tdtc_pkg::TAG_ROWS: begin
        if ((field_type == tdtc_pkg::TYPE_SHORT || field_type == tdtc_pkg::TYPE_LONG) &&
            value_count == tdtc_pkg::VALUE_ONE) begin
          st_nxt.rows = tag_value;
          st_nxt.seen[tdtc_pkg::F_ROWS] = 1'b1;
        end
      end
      tdtc_pkg::TAG_PLANAR: begin
        if (short1 && tag_value == tdtc_pkg::VALUE_ONE) begin
          st_nxt.seen[tdtc_pkg::F_PLANAR] = 1'b1;
        end
      end
      tdtc_pkg::TAG_CMAP: begin
        if (field_type == tdtc_pkg::TYPE_SHORT && (value_count == tdtc_pkg::CMAP_COUNT_FOUR ||
                                                   value_count == tdtc_pkg::CMAP_COUNT_EIGHT))
        begin
          st_nxt.cmap_ofs = tag_value;
          st_nxt.pal_size = (value_count == tdtc_pkg::CMAP_COUNT_FOUR) ?
                            tdtc_pkg::PAL_SIZE_FOUR : tdtc_pkg::PAL_SIZE_EIGHT;
          st_nxt.seen[tdtc_pkg::F_CMAP] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // clear after the last entry of a directory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= last_entry ? tdtc_pkg::tdtc_state_t'('0) : st_nxt;
    end
  end

endmodule

[rtl/tdtc_result.sv]
module tdtc_result (
  input  tdtc_pkg::tdtc_state_t  st,
  output tdtc_pkg::tdtc_result_t res
);

  tdtc_pkg::tdtc_status_t status;
  logic [16:0]            half_sum;
  logic [15:0]            half_bytes;
  logic [1:0]             pad_four;
  logic                   four_bit;
  logic                   eight_bit;

  assign four_bit  = (st.depth == tdtc_pkg::DEPTH_FOUR);
  assign eight_bit = (st.depth == tdtc_pkg::DEPTH_EIGHT);

  always_comb begin
    if ((st.seen & tdtc_pkg::F_REQUIRED) != tdtc_pkg::F_REQUIRED) begin
      status = tdtc_pkg::ST_REQ_MISSING;
    end else if (st.strips != tdtc_pkg::VALUE_ONE && !st.seen[tdtc_pkg::F_ROWS]) begin
      status = tdtc_pkg::ST_ROWS_MISSING;
    end else if (!four_bit && !eight_bit) begin
      status = tdtc_pkg::ST_BAD_DEPTH;
    end else if (!st.seen[tdtc_pkg::F_CMAP]) begin
      status = tdtc_pkg::ST_CMAP_MISSING;
    end else begin
      status = tdtc_pkg::ST_OK;
    end
  end

  // 4-bit rows pad to a multiple of four bytes
  assign half_sum   = {1'b0, st.width} + 17'd1;
  assign half_bytes = half_sum[16:1];
  assign pad_four   = 2'd0 - half_bytes[1:0];

  always_comb begin
    res.status          = status;
    res.width           = st.width;
    res.height          = st.height;
    res.eight_bit       = eight_bit;
    res.lzw             = st.comp;
    res.strip_count     = st.strips;
    res.strip_location  = (st.strips == tdtc_pkg::VALUE_ONE) ? st.single_ofs : st.table_ofs;
    res.rows_per_strip  = st.rows;
    res.colormap_offset = st.cmap_ofs;
    res.palette_entries = st.pal_size;
    res.line_bytes      = 16'd0;
    res.row_padding     = 2'd0;
    if (status == tdtc_pkg::ST_OK) begin
      if (four_bit) begin
        res.line_bytes  = half_bytes;
        res.row_padding = pad_four;
      end else begin
        res.line_bytes  = st.width;
      end
    end
  end

endmodule

[rtl/tiff_directory_tag_checker.sv]
// Checks decoded TIFF directory entries, one word per cycle, for a baseline
// palette image (4-bit or 8-bit, raw or LZW, one sample per pixel, chunky).
// The entry marked last produces one result word in the output register the
// cycle after it is accepted, and the recorded state clears for the next
// directory. Entries that are not last are always taken; a last entry waits
// only while an earlier result is still held by out_stall.
module tiff_directory_tag_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_tag_id,
  input  logic [15:0] in_field_type,
  input  logic [31:0] in_value_count,
  input  logic [31:0] in_tag_value,
  input  logic        in_last_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_width,
  output logic [15:0] out_height,
  output logic        out_eight_bit,
  output logic        out_lzw,
  output logic [31:0] out_strip_count,
  output logic [31:0] out_strip_location,
  output logic [31:0] out_rows_per_strip,
  output logic [31:0] out_colormap_offset,
  output logic [8:0]  out_palette_entries,
  output logic [15:0] out_line_bytes,
  output logic [1:0]  out_row_padding
);

  tdtc_pkg::tdtc_state_t  st_nxt;
  tdtc_pkg::tdtc_result_t res_nxt;
  tdtc_pkg::tdtc_result_t res_r;
  logic                   out_valid_r;
  logic                   accept;
  logic                   emit;

  assign in_stall = out_valid_r && out_stall && in_last_entry;
  assign accept   = in_valid && !in_stall;
  assign emit     = accept && in_last_entry;

  tdtc_entry u_entry (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .tag_id      (in_tag_id),
    .field_type  (in_field_type),
    .value_count (in_value_count),
    .tag_value   (in_tag_value),
    .last_entry  (in_last_entry),
    .st_nxt      (st_nxt)
  );

  tdtc_result u_result (
    .st  (st_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_width           = res_r.width;
  assign out_height          = res_r.height;
  assign out_eight_bit       = res_r.eight_bit;
  assign out_lzw             = res_r.lzw;
  assign out_strip_count     = res_r.strip_count;
  assign out_strip_location  = res_r.strip_location;
  assign out_rows_per_strip  = res_r.rows_per_strip;
  assign out_colormap_offset = res_r.colormap_offset;
  assign out_palette_entries = res_r.palette_entries;
  assign out_line_bytes      = res_r.line_bytes;
  assign out_row_padding     = res_r.row_padding;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam logic [15:0] TAG_STRIP_BYTES = 16'h0117;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] ftype;
    logic [31:0] count;
    logic [31:0] value;
    logic        last;
  } dir_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_tag_id = '0;
  logic [15:0] in_field_type = '0;
  logic [31:0] in_value_count = '0;
  logic [31:0] in_tag_value = '0;
  logic        in_last_entry = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic        out_eight_bit;
  logic        out_lzw;
  logic [31:0] out_strip_count;
  logic [31:0] out_strip_location;
  logic [31:0] out_rows_per_strip;
  logic [31:0] out_colormap_offset;
  logic [8:0]  out_palette_entries;
  logic [15:0] out_line_bytes;
  logic [1:0]  out_row_padding;

  dir_word_t              pending_entries[$];
  dir_word_t              dir_buf[$];
  tdtc_pkg::tdtc_result_t directory_results[$];
  tdtc_pkg::tdtc_state_t  dir_state;
  tdtc_pkg::tdtc_result_t want;
  dir_word_t              upcoming;
  bit                     messy;
  int                     gap_left;
  int                     calm_left;
  int                     stall_hold;
  int                     mismatches = 0;

  tiff_directory_tag_checker uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tag_id          (in_tag_id),
    .in_field_type      (in_field_type),
    .in_value_count     (in_value_count),
    .in_tag_value       (in_tag_value),
    .in_last_entry      (in_last_entry),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_width          (out_width),
    .out_height         (out_height),
    .out_eight_bit      (out_eight_bit),
    .out_lzw            (out_lzw),
    .out_strip_count    (out_strip_count),
    .out_strip_location (out_strip_location),
    .out_rows_per_strip (out_rows_per_strip),
    .out_colormap_offset(out_colormap_offset),
    .out_palette_entries(out_palette_entries),
    .out_line_bytes     (out_line_bytes),
    .out_row_padding    (out_row_padding)
  );

  always #4 clk = ~clk;

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void absorb_entry(input dir_word_t e);
    logic short1;
    short1 = (e.ftype == tdtc_pkg::TYPE_SHORT) && (e.count == tdtc_pkg::VALUE_ONE);
    case (e.tag)
      tdtc_pkg::TAG_WIDTH: if (short1) begin
        dir_state.width = e.value[15:0];
        dir_state.seen[tdtc_pkg::F_WIDTH] = 1'b1;
      end
      tdtc_pkg::TAG_HEIGHT: if (short1) begin
        dir_state.height = e.value[15:0];
        dir_state.seen[tdtc_pkg::F_HEIGHT] = 1'b1;
      end
      tdtc_pkg::TAG_BITS: if (short1 && (e.value == tdtc_pkg::BITS_FOUR ||
                                         e.value == tdtc_pkg::BITS_EIGHT)) begin
        dir_state.depth = (e.value == tdtc_pkg::BITS_FOUR) ? tdtc_pkg::DEPTH_FOUR
                                                           : tdtc_pkg::DEPTH_EIGHT;
        dir_state.seen[tdtc_pkg::F_BITS] = 1'b1;
      end
      tdtc_pkg::TAG_COMPRESS: if (short1 && (e.value == tdtc_pkg::COMPRESS_RAW ||
                                             e.value == tdtc_pkg::COMPRESS_LZW)) begin
        dir_state.comp = (e.value == tdtc_pkg::COMPRESS_LZW);
        dir_state.seen[tdtc_pkg::F_COMPRESS] = 1'b1;
      end
      tdtc_pkg::TAG_PHOTO: if (short1) dir_state.seen[tdtc_pkg::F_PHOTO] = 1'b1;
      tdtc_pkg::TAG_STRIPOFS: if (e.ftype == tdtc_pkg::TYPE_LONG) begin
        dir_state.strips = e.count;
        if (e.count == tdtc_pkg::VALUE_ONE) dir_state.single_ofs = e.value;
        else dir_state.table_ofs = e.value;
        dir_state.seen[tdtc_pkg::F_STRIPOFS] = 1'b1;
      end
      tdtc_pkg::TAG_SPP: if (short1 && e.value == tdtc_pkg::VALUE_ONE)
        dir_state.seen[tdtc_pkg::F_SPP] = 1'b1;
      tdtc_pkg::TAG_ROWS: if ((e.ftype == tdtc_pkg::TYPE_SHORT ||
                               e.ftype == tdtc_pkg::TYPE_LONG) &&
                              e.count == tdtc_pkg::VALUE_ONE) begin
        dir_state.rows = e.value;
        dir_state.seen[tdtc_pkg::F_ROWS] = 1'b1;
      end
      tdtc_pkg::TAG_PLANAR: if (short1 && e.value == tdtc_pkg::VALUE_ONE)
        dir_state.seen[tdtc_pkg::F_PLANAR] = 1'b1;
      tdtc_pkg::TAG_CMAP: if (e.ftype == tdtc_pkg::TYPE_SHORT &&
                              (e.count == tdtc_pkg::CMAP_COUNT_FOUR ||
                               e.count == tdtc_pkg::CMAP_COUNT_EIGHT)) begin
        dir_state.cmap_ofs = e.value;
        dir_state.pal_size = (e.count == tdtc_pkg::CMAP_COUNT_FOUR) ?
                             tdtc_pkg::PAL_SIZE_FOUR : tdtc_pkg::PAL_SIZE_EIGHT;
        dir_state.seen[tdtc_pkg::F_CMAP] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic tdtc_pkg::tdtc_result_t close_directory();
    tdtc_pkg::tdtc_result_t r;
    logic [16:0]            half;
    logic [16:0]            span;
    r = '0;
    if ((dir_state.seen & tdtc_pkg::F_REQUIRED) != tdtc_pkg::F_REQUIRED)
      r.status = tdtc_pkg::ST_REQ_MISSING;
    else if (dir_state.strips != tdtc_pkg::VALUE_ONE && !dir_state.seen[tdtc_pkg::F_ROWS])
      r.status = tdtc_pkg::ST_ROWS_MISSING;
    else if (dir_state.depth != tdtc_pkg::DEPTH_FOUR &&
             dir_state.depth != tdtc_pkg::DEPTH_EIGHT)
      r.status = tdtc_pkg::ST_BAD_DEPTH;
    else if (!dir_state.seen[tdtc_pkg::F_CMAP]) r.status = tdtc_pkg::ST_CMAP_MISSING;
    else r.status = tdtc_pkg::ST_OK;
    r.width           = dir_state.width;
    r.height          = dir_state.height;
    r.eight_bit       = (dir_state.depth == tdtc_pkg::DEPTH_EIGHT);
    r.lzw             = dir_state.comp;
    r.strip_count     = dir_state.strips;
    r.strip_location  = (dir_state.strips == tdtc_pkg::VALUE_ONE) ? dir_state.single_ofs
                                                                  : dir_state.table_ofs;
    r.rows_per_strip  = dir_state.rows;
    r.colormap_offset = dir_state.cmap_ofs;
    r.palette_entries = dir_state.pal_size;
    if (r.status == tdtc_pkg::ST_OK) begin
      if (dir_state.depth == tdtc_pkg::DEPTH_FOUR) begin
        half = ({1'b0, dir_state.width} + 17'd1) >> 1;
        span = (({1'b0, dir_state.width} + 17'd7) >> 3) << 2;
        r.line_bytes = half[15:0];
        r.row_padding = 2'(span - half);
      end else begin
        r.line_bytes = dir_state.width;
      end
    end
    dir_state = '0;
    return r;
  endfunction

  function automatic void direct(input logic [15:0] tag, input logic [15:0] ftype,
                                 input logic [31:0] count, input logic [31:0] value,
                                 input logic last);
    pending_entries.push_back('{tag, ftype, count, value, last});
  endfunction

  function automatic void stash(input logic [15:0] tag, input logic [15:0] ftype,
                                input logic [31:0] count, input logic [31:0] value);
    dir_word_t e;
    e = '{tag, ftype, count, value, 1'b0};
    if (messy && $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: e.ftype = $urandom_range(0, 1) ? 16'($urandom_range(0, 6))
                                          : 16'($urandom_range(0, 65535));
        1: e.count = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
        default: e.value = $urandom;
      endcase
    end
    dir_buf.insert($urandom_range(0, dir_buf.size()), e);
  endfunction

  function automatic bit kept();
    return !messy || $urandom_range(0, 14) != 0;
  endfunction

  function automatic logic [31:0] pick_dim();
    logic [15:0] d;
    case ($urandom_range(0, 5))
      0: d = 16'($urandom_range(0, 65535));
      1: d = 16'hffff;
      default: d = 16'($urandom_range(0, 40));
    endcase
    return {16'($urandom), d};
  endfunction

  function automatic void add_random_directory();
    dir_word_t   e;
    logic [31:0] cnt;
    int          extra;
    dir_buf.delete();
    messy = ($urandom_range(0, 9) < 4);
    if ($urandom_range(0, 19) == 0) begin
      extra = $urandom_range(1, 3);
      repeat (extra) stash(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           $urandom, $urandom);
    end else begin
      if (kept()) stash(tdtc_pkg::TAG_WIDTH, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        pick_dim());
      if (kept()) stash(tdtc_pkg::TAG_HEIGHT, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        pick_dim());
      if (kept()) stash(tdtc_pkg::TAG_BITS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        (messy && $urandom_range(0, 7) == 0) ? $urandom_range(0, 16) :
                        ($urandom_range(0, 1) ? tdtc_pkg::BITS_FOUR : tdtc_pkg::BITS_EIGHT));
      if (kept()) stash(tdtc_pkg::TAG_COMPRESS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        (messy && $urandom_range(0, 7) == 0) ? $urandom_range(0, 7) :
                        ($urandom_range(0, 1) ? tdtc_pkg::COMPRESS_RAW
                                              : tdtc_pkg::COMPRESS_LZW));
      if (kept()) stash(tdtc_pkg::TAG_PHOTO, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        $urandom_range(0, 3));
      if (kept()) begin
        case ($urandom_range(0, 9))
          0: cnt = 0;
          1: cnt = $urandom;
          2, 3, 4: cnt = $urandom_range(2, 64);
          default: cnt = tdtc_pkg::VALUE_ONE;
        endcase
        stash(tdtc_pkg::TAG_STRIPOFS, tdtc_pkg::TYPE_LONG, cnt, $urandom);
      end
      if (kept()) stash(tdtc_pkg::TAG_SPP, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        (messy && $urandom_range(0, 7) == 0) ? 2 : tdtc_pkg::VALUE_ONE);
      if (kept()) stash(tdtc_pkg::TAG_PLANAR, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                        (messy && $urandom_range(0, 7) == 0) ? 2 : tdtc_pkg::VALUE_ONE);
      if ($urandom_range(0, 3) != 0)
        stash(tdtc_pkg::TAG_ROWS,
              $urandom_range(0, 1) ? tdtc_pkg::TYPE_SHORT : tdtc_pkg::TYPE_LONG,
              tdtc_pkg::VALUE_ONE,
              $urandom_range(0, 1) ? $urandom : $urandom_range(1, 64));
      if ($urandom_range(0, 9) != 0)
        stash(tdtc_pkg::TAG_CMAP, tdtc_pkg::TYPE_SHORT,
              (messy && $urandom_range(0, 5) == 0) ? $urandom_range(0, 800) :
              ($urandom_range(0, 1) ? tdtc_pkg::CMAP_COUNT_FOUR
                                    : tdtc_pkg::CMAP_COUNT_EIGHT), $urandom);
      extra = $urandom_range(0, 3);
      repeat (extra) begin
        case ($urandom_range(0, 3))
          0: stash(TAG_STRIP_BYTES, tdtc_pkg::TYPE_LONG, $urandom_range(1, 64), $urandom);
          1: stash(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   $urandom, $urandom);
          2: stash(tdtc_pkg::TAG_WIDTH, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                   pick_dim());
          default: stash(tdtc_pkg::TAG_BITS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
                         $urandom_range(0, 1) ? tdtc_pkg::BITS_FOUR : tdtc_pkg::BITS_EIGHT);
        endcase
      end
    end
    e = dir_buf.pop_back();
    e.last = 1'b1;
    dir_buf.push_back(e);
    foreach (dir_buf[i]) pending_entries.push_back(dir_buf[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      calm_left = 0;
      dir_state = '0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_entry('{in_tag_id, in_field_type, in_value_count, in_tag_value,
                       in_last_entry});
        if (in_last_entry) directory_results.push_back(close_directory());
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_entries.size() != 0) begin
          upcoming = pending_entries.pop_front();
          in_tag_id      <= upcoming.tag;
          in_field_type  <= upcoming.ftype;
          in_value_count <= upcoming.count;
          in_tag_value   <= upcoming.value;
          in_last_entry  <= upcoming.last;
          in_valid       <= 1'b1;
          if (calm_left != 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            gap_left = gap_length();
            if ($urandom_range(0, 59) == 0) calm_left = 40;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (directory_results.size() == 0) begin
          note_mismatch("result word with no directory closed");
        end else begin
          want = directory_results.pop_front();
          if (out_status !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_width !== want.width)
            note_mismatch($sformatf("width %0h, want %0h", out_width, want.width));
          if (out_height !== want.height)
            note_mismatch($sformatf("height %0h, want %0h", out_height, want.height));
          if (out_eight_bit !== want.eight_bit)
            note_mismatch($sformatf("eight_bit %0b, want %0b", out_eight_bit, want.eight_bit));
          if (out_lzw !== want.lzw)
            note_mismatch($sformatf("lzw %0b, want %0b", out_lzw, want.lzw));
          if (out_strip_count !== want.strip_count)
            note_mismatch($sformatf("strip_count %0h, want %0h", out_strip_count,
                                    want.strip_count));
          if (out_strip_location !== want.strip_location)
            note_mismatch($sformatf("strip_location %0h, want %0h", out_strip_location,
                                    want.strip_location));
          if (out_rows_per_strip !== want.rows_per_strip)
            note_mismatch($sformatf("rows_per_strip %0h, want %0h", out_rows_per_strip,
                                    want.rows_per_strip));
          if (out_colormap_offset !== want.colormap_offset)
            note_mismatch($sformatf("colormap_offset %0h, want %0h", out_colormap_offset,
                                    want.colormap_offset));
          if (out_palette_entries !== want.palette_entries)
            note_mismatch($sformatf("palette_entries %0d, want %0d", out_palette_entries,
                                    want.palette_entries));
          if (out_line_bytes !== want.line_bytes)
            note_mismatch($sformatf("line_bytes %0h, want %0h", out_line_bytes,
                                    want.line_bytes));
          if (out_row_padding !== want.row_padding)
            note_mismatch($sformatf("row_padding %0d, want %0d", out_row_padding,
                                    want.row_padding));
        end
      end
      if (stall_hold != 0) begin
        stall_hold--;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        stall_hold = gap_length();
      end
    end
  end

  initial begin
    direct(16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);

    direct(tdtc_pkg::TAG_WIDTH, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE, 32'd5, 1'b0);
    direct(tdtc_pkg::TAG_WIDTH, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           32'habcd_ffff, 1'b0);
    direct(tdtc_pkg::TAG_HEIGHT, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE, 32'd0, 1'b0);
    direct(tdtc_pkg::TAG_BITS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::BITS_FOUR, 1'b0);
    direct(tdtc_pkg::TAG_COMPRESS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::COMPRESS_LZW, 1'b0);
    direct(tdtc_pkg::TAG_PHOTO, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE, 32'd3, 1'b0);
    direct(tdtc_pkg::TAG_STRIPOFS, tdtc_pkg::TYPE_LONG, tdtc_pkg::VALUE_ONE,
           32'hffff_ffff, 1'b0);
    direct(tdtc_pkg::TAG_SPP, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::VALUE_ONE, 1'b0);
    direct(tdtc_pkg::TAG_PLANAR, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::VALUE_ONE, 1'b0);
    direct(tdtc_pkg::TAG_CMAP, tdtc_pkg::TYPE_SHORT, tdtc_pkg::CMAP_COUNT_FOUR, 32'd0, 1'b1);

    direct(tdtc_pkg::TAG_WIDTH, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE, 32'd7, 1'b0);
    direct(tdtc_pkg::TAG_HEIGHT, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           32'h1234_ffff, 1'b0);
    direct(tdtc_pkg::TAG_BITS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::BITS_EIGHT, 1'b0);
    direct(tdtc_pkg::TAG_COMPRESS, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::COMPRESS_RAW, 1'b0);
    direct(tdtc_pkg::TAG_PHOTO, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE, 32'd0, 1'b0);
    direct(tdtc_pkg::TAG_STRIPOFS, tdtc_pkg::TYPE_LONG, 32'hffff_ffff, 32'd0, 1'b0);
    direct(tdtc_pkg::TAG_SPP, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::VALUE_ONE, 1'b0);
    direct(tdtc_pkg::TAG_PLANAR, tdtc_pkg::TYPE_SHORT, tdtc_pkg::VALUE_ONE,
           tdtc_pkg::VALUE_ONE, 1'b0);
    direct(tdtc_pkg::TAG_ROWS, tdtc_pkg::TYPE_LONG, tdtc_pkg::VALUE_ONE,
           32'hffff_ffff, 1'b0);
    direct(TAG_STRIP_BYTES, tdtc_pkg::TYPE_LONG, 32'd3, 32'h0000_0100, 1'b0);
    direct(tdtc_pkg::TAG_CMAP, tdtc_pkg::TYPE_SHORT, tdtc_pkg::CMAP_COUNT_EIGHT,
           32'hffff_ffff, 1'b1);

    while (pending_entries.size() < 1450) add_random_directory();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_entries.size() != 0 || in_valid || directory_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/tdtc_pkg.sv
rtl/tdtc_entry.sv
rtl/tdtc_result.sv
rtl/tiff_directory_tag_checker.sv
tb/sv/testbench.sv
